// ----- design/hgc_pkg.sv -----
// Shared types, constants and the arctangent table of the haversine geofence check.
package hgc_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int XW = 34;
  localparam int ZW = 34;

  localparam logic [1:0] REG_HOME_LAT  = 2'd0;
  localparam logic [1:0] REG_HOME_LON  = 2'd1;
  localparam logic [1:0] REG_DIST_LIM  = 2'd2;
  localparam logic [1:0] REG_SPEED_LIM = 2'd3;

  localparam logic signed [35:0] TURN_S      = 36'sd3600000000;
  localparam logic [28:0]        ANG_K       = 29'd320255974;
  localparam logic [24:0]        DIST_MAX    = 25'd20015087;
  localparam logic [30:0]        DIST_SCALE  = 31'd1280965555;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ZW-1:0] Q30_S     = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_S    = 34'sd2147483648;
  localparam logic [30:0]        Q30_ONE     = 31'd1073741824;
  localparam logic [15:0]        SPEED_MAX   = 16'hFFFF;

  typedef struct packed {
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic [15:0]        speed;
  } in_t;

  typedef struct packed {
    logic [24:0] distance;
    logic        out_of_range;
    logic        over_speed;
  } out_t;

  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/haversine_geofence_check.sv -----
// Pipelined haversine distance from a home point with range and speed flags.
//
//  channel | ports                          | handshake
//  input   | start, busy, in_data           | item taken when start & !busy
//  result  | out_valid, out_data            | one-cycle strobe, no back-pressure
//  config  | cfg_we, cfg_idx, cfg_wdata     | write when cfg_we is high
//
// One item per cycle; busy stays low. The pipeline holds the two CORDIC chains
// (one micro-rotation per stage) and the 31-stage square root. Synchronous reset
// clears valid bits and home point, and sets the distance and speed limits to max.
// Results leave on a strobe; the receiver cannot stall, so the pipeline never halts.
module haversine_geofence_check #(
  parameter int CORDIC_STAGES = hgc_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hgc_pkg::in_t  in_data,
  output logic          out_valid,
  output hgc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [31:0]   cfg_wdata
);
  import hgc_pkg::*;

  localparam int CS  = CORDIC_STAGES;
  localparam int SQ  = 31;
  localparam int LAT = 41 + 2 * CS;

  logic signed [30:0] hlat_r;
  logic signed [31:0] hlon_r;
  logic [24:0]        dlim_r;
  logic [15:0]        slim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlat_r <= '0;
      hlon_r <= '0;
      dlim_r <= DIST_MAX;
      slim_r <= SPEED_MAX;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HOME_LAT:  hlat_r <= cfg_wdata[30:0];
        REG_HOME_LON:  hlon_r <= cfg_wdata;
        REG_DIST_LIM:  dlim_r <= cfg_wdata[24:0];
        REG_SPEED_LIM: slim_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [LAT-1:0] vld_r;
  logic [15:0]    spd_r [LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    spd_r[0] <= in_data.speed;
    for (int k = 1; k < LAT - 1; k++) begin
      spd_r[k] <= spd_r[k-1];
    end
  end

  // angle differences and raw angles
  logic signed [33:0] d_r [4];

  always_ff @(posedge clk) begin
    d_r[0] <= 34'(hlat_r) - 34'(in_data.latitude);
    d_r[1] <= 34'(hlon_r) - 34'(in_data.longitude);
    d_r[2] <= 34'(in_data.latitude);
    d_r[3] <= 34'(hlat_r);
  end

  function automatic logic [31:0] wrap_turn(input logic signed [33:0] v);
    logic signed [35:0] t;
    t = 36'(v);
    if (t < 0) t = t + TURN_S;
    if (t < 0) t = t + TURN_S;
    if (t >= TURN_S) t = t - TURN_S;
    return t[31:0];
  endfunction

  logic [31:0]        r_r [4];
  logic [60:0]        p_r [4];
  logic signed [XW-1:0] cx_r [4][CS+1];
  logic signed [XW-1:0] cy_r [4][CS+1];
  logic signed [ZW-1:0] cz_r [4][CS+1];
  logic                 cn_r [4][CS+1];
  logic signed [XW-1:0] cf [4];
  logic signed [XW-1:0] sf [4];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam int SH = (j < 2) ? 29 : 28;
    logic [31:0]          ang;
    logic signed [ZW-1:0] zf;
    logic                 nf;

    always_ff @(posedge clk) begin
      r_r[j] <= wrap_turn(d_r[j]);
      p_r[j] <= 61'(r_r[j]) * 61'(ANG_K);
    end

    always_comb begin
      ang = 32'((62'(p_r[j]) + (62'(1) << (SH - 1))) >> SH);
      zf  = ZW'($signed(ang));
      nf  = 1'b0;
      if (zf > Q30_S) begin
        zf = zf - HALF_S;
        nf = 1'b1;
      end else if (zf < -Q30_S) begin
        zf = zf + HALF_S;
        nf = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      cx_r[j][0] <= CORDIC_GAIN;
      cy_r[j][0] <= '0;
      cz_r[j][0] <= zf;
      cn_r[j][0] <= nf;
    end

    for (genvar i = 0; i < CS; i++) begin : g_rot
      localparam logic signed [ZW-1:0] AT = ZW'(atan_val(5'(i)));
      always_ff @(posedge clk) begin
        cn_r[j][i+1] <= cn_r[j][i];
        if (cz_r[j][i] >= 0) begin
          cx_r[j][i+1] <= cx_r[j][i] - (cy_r[j][i] >>> i);
          cy_r[j][i+1] <= cy_r[j][i] + (cx_r[j][i] >>> i);
          cz_r[j][i+1] <= cz_r[j][i] - AT;
        end else begin
          cx_r[j][i+1] <= cx_r[j][i] + (cy_r[j][i] >>> i);
          cy_r[j][i+1] <= cy_r[j][i] - (cx_r[j][i] >>> i);
          cz_r[j][i+1] <= cz_r[j][i] + AT;
        end
      end
    end

    assign cf[j] = cn_r[j][CS] ? -cx_r[j][CS] : cx_r[j][CS];
    assign sf[j] = cn_r[j][CS] ? -cy_r[j][CS] : cy_r[j][CS];
  end

  // haversine term
  logic signed [2*XW-1:0] pr_h1, pr_h2, pr_cc;
  logic signed [37:0]     h1_r, h2_r, cc_r;

  always_comb begin
    pr_h1 = sf[0] * sf[0];
    pr_h2 = sf[1] * sf[1];
    pr_cc = cf[2] * cf[3];
  end

  always_ff @(posedge clk) begin
    h1_r <= 38'(pr_h1 >>> 30);
    h2_r <= 38'(pr_h2 >>> 30);
    cc_r <= 38'(pr_cc >>> 30);
  end

  logic signed [75:0] pr_a;
  logic signed [39:0] a_sum;
  logic [30:0]        a_nxt, a_r;

  always_comb begin
    pr_a  = cc_r * h2_r;
    a_sum = 40'(h1_r) + 40'(pr_a >>> 30);
    if (a_sum < 0) begin
      a_nxt = '0;
    end else if (a_sum > 40'(Q30_S)) begin
      a_nxt = Q30_ONE;
    end else begin
      a_nxt = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

  // bit-serial square roots of a and 1 - a, one result bit per stage
  logic [60:0] sv_r [2][SQ+1];
  logic [61:0] sr_r [2][SQ+1];

  always_ff @(posedge clk) begin
    sv_r[0][0] <= {a_r, 30'b0};
    sv_r[1][0] <= {Q30_ONE - a_r, 30'b0};
    sr_r[0][0] <= '0;
    sr_r[1][0] <= '0;
  end

  for (genvar q = 0; q < 2; q++) begin : g_sqrt
    for (genvar k = 0; k < SQ; k++) begin : g_step
      localparam logic [61:0] BITK = 62'(1) << (60 - 2 * k);
      logic [61:0] sum;
      assign sum = sr_r[q][k] + BITK;
      always_ff @(posedge clk) begin
        if (62'(sv_r[q][k]) >= sum) begin
          sv_r[q][k+1] <= 61'(62'(sv_r[q][k]) - sum);
          sr_r[q][k+1] <= (sr_r[q][k] >> 1) + BITK;
        end else begin
          sv_r[q][k+1] <= sv_r[q][k];
          sr_r[q][k+1] <= sr_r[q][k] >> 1;
        end
      end
    end
  end

  // atan2 by vectoring
  logic signed [XW-1:0] vx_r [CS+1];
  logic signed [XW-1:0] vy_r [CS+1];
  logic signed [ZW-1:0] vz_r [CS+1];

  always_ff @(posedge clk) begin
    vx_r[0] <= XW'(sr_r[1][SQ]);
    vy_r[0] <= XW'(sr_r[0][SQ]);
    vz_r[0] <= '0;
  end

  for (genvar i = 0; i < CS; i++) begin : g_vec
    localparam logic signed [ZW-1:0] AT = ZW'(atan_val(5'(i)));
    always_ff @(posedge clk) begin
      if (vy_r[i] > 0) begin
        vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] + AT;
      end else begin
        vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] - AT;
      end
    end
  end

  // scale to meters and flag
  logic [30:0] zc;
  logic [61:0] zm_r;

  always_comb begin
    if (vz_r[CS] < 0) begin
      zc = '0;
    end else if (vz_r[CS] > Q30_S) begin
      zc = Q30_ONE;
    end else begin
      zc = vz_r[CS][30:0];
    end
  end

  always_ff @(posedge clk) begin
    zm_r <= 62'(zc) * 62'(DIST_SCALE);
  end

  logic [26:0] d_raw;
  logic [24:0] dist_sat;
  out_t        out_r;

  always_comb begin
    d_raw    = 27'((63'(zm_r) + (63'(1) << 35)) >> 36);
    dist_sat = (d_raw > 27'(DIST_MAX)) ? DIST_MAX : d_raw[24:0];
  end

  always_ff @(posedge clk) begin
    out_r.distance     <= dist_sat;
    out_r.out_of_range <= dist_sat > dlim_r;
    out_r.over_speed   <= spd_r[LAT-2] > slim_r;
  end

  assign out_data  = out_r;
  assign out_valid = vld_r[LAT-1];

endmodule

// ----- design/hgc_checker.sv -----
// Port-level checks of the haversine geofence check, bound to the top level.
module hgc_checker #(
  parameter int CORDIC_STAGES = hgc_pkg::CORDIC_STAGES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input hgc_pkg::in_t  in_data,
  input logic          out_valid,
  input hgc_pkg::out_t out_data
);
  import hgc_pkg::*;

  localparam int LAT = 41 + 2 * CORDIC_STAGES;

  a_item_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an item taken");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.distance <= DIST_MAX)
    else $error("distance above half circumference");

  a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_of_range) |-> out_data.distance != '0)
    else $error("zero distance flagged out of range");

  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.speed, LAT) == '0) |-> !out_data.over_speed)
    else $error("zero speed flagged over speed");

endmodule

bind haversine_geofence_check hgc_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_hgc_checker (.*);

// ----- tb/haversine_geofence_check_tb.sv -----
// Self-checking testbench for the haversine geofence check: directed and random fixes.
`timescale 1ns / 100ps

module haversine_geofence_check_tb;
  import hgc_pkg::*;

  localparam int STAGES = 24;
  localparam longint TURN = 64'sd3600000000;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint unsigned ANG_MUL = 64'd320255974;
  localparam longint unsigned METER_SCALE = 64'd1280965555;
  localparam longint unsigned FAR_MAX = 64'd20015087;
  localparam longint GAIN = 64'sd652032874;

  localparam longint ARC_TAB [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = REG_HOME_LAT;
  logic [31:0] cfg_wdata = '0;

  logic signed [30:0] home_lat;
  logic signed [31:0] home_lon;
  logic [24:0]        far_limit;
  logic [15:0]        fast_limit;

  in_t  fix_q[$];
  out_t fence_q[$];
  int   mismatches = 0;
  int   gap = 0;
  bit   no_gaps = 0;

  haversine_geofence_check dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned to_binang(longint v, int sh);
    longint r;
    longint unsigned p;
    r = v % TURN;
    if (r < 0) r += TURN;
    p = longint'(r) * ANG_MUL + (64'd1 << (sh - 1));
    return (p >> sh) & 64'hFFFF_FFFF;
  endfunction

  function automatic void rotate(input longint unsigned ang, output longint c,
                                 output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang & 64'hFFFF_FFFF);
    flip = 0;
    x = GAIN;
    y = 0;
    if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
    if (z > ONE_Q30) begin
      z -= (64'sd1 << 31);
      flip = 1;
    end else if (z < -ONE_Q30) begin
      z += (64'sd1 << 31);
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end else begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint central_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic out_t fence_predict(in_t f);
    longint lat, lon, hlat, hlon, c1, s1, c2, s2, cl, sl, ch, sh;
    longint h1, h2, cc, a, sa, sb, z;
    longint unsigned d;
    out_t r;
    lat = longint'(f.latitude);
    lon = longint'(f.longitude);
    hlat = longint'(home_lat);
    hlon = longint'(home_lon);
    rotate(to_binang(hlat - lat, 29), c1, s1);
    rotate(to_binang(hlon - lon, 29), c2, s2);
    rotate(to_binang(lat, 28), cl, sl);
    rotate(to_binang(hlat, 28), ch, sh);
    h1 = (s1 * s1) >>> 30;
    h2 = (s2 * s2) >>> 30;
    cc = (cl * ch) >>> 30;
    a = h1 + ((cc * h2) >>> 30);
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    sa = longint'(int_sqrt(longint'(a) << 30));
    sb = longint'(int_sqrt(longint'(ONE_Q30 - a) << 30));
    z = central_angle(sa, sb);
    if (z < 0) z = 0;
    if (z > ONE_Q30) z = ONE_Q30;
    d = (longint'(z) * METER_SCALE + (64'd1 << 35)) >> 36;
    if (d > FAR_MAX) d = FAR_MAX;
    r.distance = d[24:0];
    r.out_of_range = (d[24:0] > far_limit);
    r.over_speed = (f.speed > fast_limit);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      if (start && !busy) fence_q.push_back(fence_predict(in_data));
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap > 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (fix_q.size() > 0) begin
        in_data <= fix_q.pop_front();
        start <= 1'b1;
        if (no_gaps || $urandom_range(0, 9) < 6) gap <= 0;
        else if ($urandom_range(0, 9) < 8) gap <= $urandom_range(1, 3);
        else gap <= $urandom_range(10, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (fence_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_data);
      end else begin
        want = fence_q.pop_front();
        if (out_data.distance !== want.distance ||
            out_data.out_of_range !== want.out_of_range ||
            out_data.over_speed !== want.over_speed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected dist=%0d oor=%0b ovs=%0b got dist=%0d oor=%0b ovs=%0b",
                     want.distance, want.out_of_range, want.over_speed,
                     out_data.distance, out_data.out_of_range, out_data.over_speed);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_HOME_LAT:  home_lat = v[30:0];
      REG_HOME_LON:  home_lon = v;
      REG_DIST_LIM:  far_limit = v[24:0];
      REG_SPEED_LIM: fast_limit = v[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_fix(logic [30:0] lat, logic [31:0] lon, logic [15:0] spd);
    in_t f;
    f.latitude = lat;
    f.longitude = lon;
    f.speed = spd;
    fix_q.push_back(f);
  endtask

  task automatic add_random(int n);
    logic [30:0] lat;
    logic [31:0] lon;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
        lon = 32'($urandom_range(0, 32'd3600000000) - 32'd1800000000);
      end else begin
        lat = 31'($urandom());
        lon = $urandom();
      end
      add_fix(lat, lon, 16'($urandom()));
    end
  endtask

  task automatic drain();
    while (fix_q.size() > 0 || start || fence_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    home_lat = '0;
    home_lon = '0;
    far_limit = 25'd20015087;
    fast_limit = 16'hFFFF;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    add_fix(31'sd0, 32'sd0, 16'd0);
    add_fix(31'sd900000000, 32'sd0, 16'hFFFF);
    add_fix(-31'sd900000000, 32'sd0, 16'd1);
    add_fix(31'sd0, 32'sd1800000000, 16'hFFFE);
    add_fix(31'sd0, -32'sd1800000000, 16'd0);
    add_fix(31'h4000_0000, 32'h8000_0000, 16'h8000);
    add_fix(31'h3FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    add_fix(31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd1);
    add_fix(31'sd450000000, 32'sd900000000, 16'd100);
    add_fix(31'sd1, 32'sd1, 16'd0);
    add_fix(31'sd899999999, -32'sd1799999999, 16'hFFFF);
    drain();

    write_reg(REG_HOME_LAT, 32'(-900000000));
    write_reg(REG_HOME_LON, 32'(1800000000));
    write_reg(REG_DIST_LIM, 32'd0);
    write_reg(REG_SPEED_LIM, 32'd0);
    add_fix(31'sd900000000, 32'sd0, 16'd0);
    add_fix(-31'sd900000000, 32'sd1800000000, 16'd1);
    add_fix(31'sd0, 32'sd0, 16'hFFFF);
    add_fix(31'h4000_0000, 32'h8000_0000, 16'd5);
    add_random(90);
    drain();

    write_reg(REG_HOME_LAT, 32'h4000_0000);
    write_reg(REG_HOME_LON, 32'h7FFF_FFFF);
    write_reg(REG_DIST_LIM, 32'h01FF_FFFF);
    write_reg(REG_SPEED_LIM, 32'hFFFF);
    add_random(90);
    drain();

    for (int p = 0; p < 4; p++) begin
      no_gaps = (p == 1);
      write_reg(REG_HOME_LAT, 32'($signed($urandom_range(0, 1800000000)) - 900000000));
      write_reg(REG_HOME_LON, 32'($urandom_range(0, 32'd3600000000) - 32'd1800000000));
      write_reg(REG_DIST_LIM, 32'($urandom_range(0, 20015087)));
      write_reg(REG_SPEED_LIM, 32'($urandom_range(0, 65535)));
      add_random(90);
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
design/hgc_pkg.sv
design/haversine_geofence_check.sv
design/hgc_checker.sv
tb/haversine_geofence_check_tb.sv
